### hw/rtl/pgt_pkg.sv
// ----------------------------------------------------------------------------
// pgt_pkg
// shared constants, codes and types of the palette gradient table
// ----------------------------------------------------------------------------
`default_nettype none

package pgt_pkg;

    // table geometry
    localparam int TABLE_DEPTH  = 256;
    localparam int CHANNEL_BITS = 8;
    localparam int NUM_CH       = 3;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int PIXEL_W      = NUM_CH * CHANNEL_BITS;
    localparam int CH_SEL_W     = 2;

    // register and result widths
    localparam int CFG_W        = 9;
    localparam int OUT_W        = 9;
    localparam int DELTA_W      = CHANNEL_BITS + 1;
    localparam int DIV_CNT_W    = (CHANNEL_BITS > 1) ? $clog2(CHANNEL_BITS) : 1;

    localparam logic [CFG_W-1:0] NUM_COLORS_RESET = CFG_W'(256);

    // action codes
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_FILL  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_FILL
    } state_t;

    // divider request and response
    typedef struct packed {
        logic                    start;
        logic                    negative;
        logic [CHANNEL_BITS-1:0] dividend;
        logic [ADDR_W-1:0]       divisor;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [DELTA_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/palette_gradient_table_top.sv
// ----------------------------------------------------------------------------
// palette_gradient_table_top
// rgb palette store with read, write and linear gradient fill
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; every command
// gives exactly one result beat, shown on out_red/out_green/out_blue/accepted
// for the single cycle in which done is high. The receiver cannot stall, so
// capture on done. A write, an out-of-range read, a refused fill or an unused
// action code answers in the next cycle after the accepting edge and never raises
// busy, so such beats can follow each other every cycle. An in-range read passes
// through ST_READ and the registered ram read before its result beat.
// A fill runs the one shared divider three times (one channel each, one
// quotient bit per cycle), then writes one entry per cycle from index to
// end_index, skipping entries past num_colors, with busy high throughout.
// The table clears to black at reset through per-entry valid flags, so no
// clearing pass is needed. num_colors may only be written while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_gradient_table_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // command beat
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [1:0]                            action,
    input  wire logic [pgt_pkg::ADDR_W-1:0]            index,
    input  wire logic [pgt_pkg::ADDR_W-1:0]            end_index,
    input  wire logic [pgt_pkg::CHANNEL_BITS-1:0]      red,
    input  wire logic [pgt_pkg::CHANNEL_BITS-1:0]      green,
    input  wire logic [pgt_pkg::CHANNEL_BITS-1:0]      blue,
    input  wire logic [pgt_pkg::CHANNEL_BITS-1:0]      red_end,
    input  wire logic [pgt_pkg::CHANNEL_BITS-1:0]      green_end,
    input  wire logic [pgt_pkg::CHANNEL_BITS-1:0]      blue_end,
    // result beat
    output logic                                       done,
    output logic signed [pgt_pkg::OUT_W-1:0]           out_red,
    output logic signed [pgt_pkg::OUT_W-1:0]           out_green,
    output logic signed [pgt_pkg::OUT_W-1:0]           out_blue,
    output logic                                       accepted,
    // num_colors register
    input  wire logic                                  cfg_we,
    input  wire logic [pgt_pkg::CFG_W-1:0]             cfg_wdata
);

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    pgt_pkg::state_t                          state_reg;
    pgt_pkg::state_t                          state_next;
    logic                                     done_reg;
    logic                                     done_next;
    logic [pgt_pkg::CFG_W-1:0]                num_colors_reg;
    logic [pgt_pkg::TABLE_DEPTH-1:0]          valid_reg;
    logic                                     valid_rd_reg;

    // fill bookkeeping
    logic [pgt_pkg::ADDR_W-1:0]               pos_reg;
    logic [pgt_pkg::ADDR_W-1:0]               end_reg;
    logic [pgt_pkg::ADDR_W-1:0]               span_reg;
    logic [pgt_pkg::CH_SEL_W-1:0]             ch_reg;
    logic [pgt_pkg::CHANNEL_BITS-1:0]         color_reg [pgt_pkg::NUM_CH];
    logic [pgt_pkg::CHANNEL_BITS-1:0]         target_reg [pgt_pkg::NUM_CH];
    logic signed [pgt_pkg::DELTA_W-1:0]       delta_reg [pgt_pkg::NUM_CH];

    // result registers
    logic signed [pgt_pkg::OUT_W-1:0]         out_red_reg;
    logic signed [pgt_pkg::OUT_W-1:0]         out_green_reg;
    logic signed [pgt_pkg::OUT_W-1:0]         out_blue_reg;
    logic                                     accepted_reg;

    // ------------------------------------------------------------------
    // decode of the incoming beat
    // ------------------------------------------------------------------
    logic                                     accept;
    logic                                     idx_in_range;
    logic                                     fill_ok;
    logic                                     pos_in_range;
    logic                                     last_ch;
    logic                                     fill_last;

    assign accept       = start && !busy;
    assign idx_in_range = ({1'b0, index} < num_colors_reg);
    assign fill_ok      = (index < end_index);
    assign pos_in_range = ({1'b0, pos_reg} < num_colors_reg);
    assign last_ch      = (ch_reg == pgt_pkg::CH_SEL_W'(pgt_pkg::NUM_CH - 1));
    assign fill_last    = (pos_reg == end_reg);

    // ------------------------------------------------------------------
    // palette ram and shared divider
    // ------------------------------------------------------------------
    logic                                     ram_we;
    logic [pgt_pkg::ADDR_W-1:0]               ram_waddr;
    logic [pgt_pkg::PIXEL_W-1:0]              ram_wdata;
    logic                                     ram_re;
    logic [pgt_pkg::PIXEL_W-1:0]              ram_rdata;

    pgt_ram #(
        .WIDTH (pgt_pkg::PIXEL_W),
        .DEPTH (pgt_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (index),
        .rdata (ram_rdata)
    );

    pgt_pkg::div_req_t                        div_req;
    pgt_pkg::div_rsp_t                        div_rsp;
    logic signed [pgt_pkg::DELTA_W-1:0]       diff;

    // end minus start of the channel being divided
    assign diff = $signed({1'b0, target_reg[ch_reg]}) - $signed({1'b0, color_reg[ch_reg]});

    pgt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pgt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if ((action == pgt_pkg::ACT_READ) && idx_in_range)
                    begin
                        state_next = pgt_pkg::ST_READ;
                    end
                    else if ((action == pgt_pkg::ACT_FILL) && fill_ok)
                    begin
                        state_next = pgt_pkg::ST_DIV_LOAD;
                    end
                end
            end
            pgt_pkg::ST_READ:
            begin
                state_next = pgt_pkg::ST_IDLE;
            end
            pgt_pkg::ST_DIV_LOAD:
            begin
                state_next = pgt_pkg::ST_DIV_WAIT;
            end
            pgt_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = last_ch ? pgt_pkg::ST_FILL : pgt_pkg::ST_DIV_LOAD;
                end
            end
            pgt_pkg::ST_FILL:
            begin
                if (fill_last)
                begin
                    state_next = pgt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pgt_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // outputs of the sequencer
    // ------------------------------------------------------------------
    logic                                     res_load;
    logic signed [pgt_pkg::OUT_W-1:0]         res_red;
    logic signed [pgt_pkg::OUT_W-1:0]         res_green;
    logic signed [pgt_pkg::OUT_W-1:0]         res_blue;
    logic                                     res_acc;

    always_comb
    begin
        busy             = (state_reg != pgt_pkg::ST_IDLE);
        ram_we           = 1'b0;
        ram_waddr        = index;
        ram_wdata        = {red, green, blue};
        ram_re           = 1'b0;
        div_req.start    = 1'b0;
        div_req.negative = diff[pgt_pkg::DELTA_W-1];
        div_req.dividend = diff[pgt_pkg::DELTA_W-1] ?
                           pgt_pkg::CHANNEL_BITS'(-diff) : pgt_pkg::CHANNEL_BITS'(diff);
        div_req.divisor  = span_reg;
        res_load         = 1'b0;
        res_red          = '0;
        res_green        = '0;
        res_blue         = '0;
        res_acc          = 1'b0;
        unique case (state_reg)
            pgt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        pgt_pkg::ACT_READ:
                        begin
                            // in range goes through the ram, out of range answers at once
                            ram_re   = idx_in_range;
                            res_load = !idx_in_range;
                            res_red   = '1;
                            res_green = '1;
                            res_blue  = '1;
                        end
                        pgt_pkg::ACT_WRITE:
                        begin
                            ram_we   = idx_in_range;
                            res_load = 1'b1;
                            res_acc  = idx_in_range;
                        end
                        pgt_pkg::ACT_FILL:
                        begin
                            res_load = !fill_ok;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            pgt_pkg::ST_READ:
            begin
                // never-written entries read as black
                res_load = 1'b1;
                res_acc  = 1'b1;
                if (valid_rd_reg)
                begin
                    res_red   = $signed(pgt_pkg::OUT_W'(ram_rdata[3*pgt_pkg::CHANNEL_BITS-1:
                                                                2*pgt_pkg::CHANNEL_BITS]));
                    res_green = $signed(pgt_pkg::OUT_W'(ram_rdata[2*pgt_pkg::CHANNEL_BITS-1:
                                                                pgt_pkg::CHANNEL_BITS]));
                    res_blue  = $signed(pgt_pkg::OUT_W'(ram_rdata[pgt_pkg::CHANNEL_BITS-1:0]));
                end
            end
            pgt_pkg::ST_DIV_LOAD:
            begin
                div_req.start = 1'b1;
            end
            pgt_pkg::ST_DIV_WAIT:
            begin
                div_req.start = 1'b0;
            end
            pgt_pkg::ST_FILL:
            begin
                // entries past the active size are skipped
                ram_we    = pos_in_range;
                ram_waddr = pos_reg;
                ram_wdata = {color_reg[0], color_reg[1], color_reg[2]};
                res_load  = fill_last;
                res_acc   = 1'b1;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
        done_next = res_load;
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pgt_pkg::ST_IDLE;
            done_reg       <= 1'b0;
            num_colors_reg <= pgt_pkg::NUM_COLORS_RESET;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                num_colors_reg <= cfg_wdata;
            end
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            valid_rd_reg <= valid_reg[index];
        end

        if (res_load)
        begin
            out_red_reg   <= res_red;
            out_green_reg <= res_green;
            out_blue_reg  <= res_blue;
            accepted_reg  <= res_acc;
        end

        if (accept)
        begin
            // start colour doubles as the running fill colour
            pos_reg       <= index;
            end_reg       <= end_index;
            span_reg      <= end_index - index;
            ch_reg        <= '0;
            color_reg[0]  <= red;
            color_reg[1]  <= green;
            color_reg[2]  <= blue;
            target_reg[0] <= red_end;
            target_reg[1] <= green_end;
            target_reg[2] <= blue_end;
        end
        else if ((state_reg == pgt_pkg::ST_DIV_WAIT) && div_rsp.done)
        begin
            delta_reg[ch_reg] <= div_rsp.quotient;
            ch_reg            <= ch_reg + 1'b1;
        end
        else if (state_reg == pgt_pkg::ST_FILL)
        begin
            pos_reg <= pos_reg + 1'b1;
            for (int c = 0; c < pgt_pkg::NUM_CH; c++)
            begin
                color_reg[c] <= pgt_pkg::CHANNEL_BITS'($signed({1'b0, color_reg[c]})
                                                       + delta_reg[c]);
            end
        end
    end

    assign done      = done_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign accepted  = accepted_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_busy_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result beat while a command is still running");

    a_read_to_ram: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == pgt_pkg::ACT_READ) && idx_in_range)
        |=> (state_reg == pgt_pkg::ST_READ))
        else $error("in-range read did not go through the ram");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == pgt_pkg::ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_fill_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pgt_pkg::ST_FILL) |-> (pos_reg <= end_reg))
        else $error("fill walked past its end entry");

    a_ram_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == pgt_pkg::ST_FILL)
                    || (accept && (action == pgt_pkg::ACT_WRITE))))
        else $error("palette written outside a write or fill");

endmodule

`default_nettype wire

### hw/rtl/pgt_ram.sv
// ----------------------------------------------------------------------------
// pgt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pgt_div.sv
// ----------------------------------------------------------------------------
// pgt_div
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module pgt_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pgt_pkg::div_req_t req,
    output pgt_pkg::div_rsp_t      rsp
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [pgt_pkg::DIV_CNT_W-1:0]       cnt_reg;
    logic [pgt_pkg::ADDR_W-1:0]          rem_reg;
    logic [pgt_pkg::CHANNEL_BITS-1:0]    quo_reg;
    logic [pgt_pkg::ADDR_W-1:0]          divisor_reg;
    logic                                neg_reg;

    logic [pgt_pkg::ADDR_W:0]            shifted;
    logic [pgt_pkg::ADDR_W:0]            trial;
    logic                                fits;

    // shift in the next dividend bit and try the subtract
    assign shifted = {rem_reg, quo_reg[pgt_pkg::CHANNEL_BITS-1]};
    assign trial   = shifted - {1'b0, divisor_reg};
    assign fits    = (shifted >= {1'b0, divisor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (cnt_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            cnt_reg     <= pgt_pkg::DIV_CNT_W'(pgt_pkg::CHANNEL_BITS - 1);
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
            neg_reg     <= req.negative;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            rem_reg <= fits ? trial[pgt_pkg::ADDR_W-1:0] : shifted[pgt_pkg::ADDR_W-1:0];
            quo_reg <= {quo_reg[pgt_pkg::CHANNEL_BITS-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

`default_nettype wire

### tb/sv/palette_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_checker
// watches the command, result and register ports of the palette table,
// keeps its own copy of the table and checks every result beat in order
// ----------------------------------------------------------------------------

module palette_checker (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic                                  busy,
    input  wire logic [1:0]                            action,
    input  wire logic [pgt_pkg::ADDR_W-1:0]            index,
    input  wire logic [pgt_pkg::ADDR_W-1:0]            end_index,
    input  wire logic [pgt_pkg::CHANNEL_BITS-1:0]      red,
    input  wire logic [pgt_pkg::CHANNEL_BITS-1:0]      green,
    input  wire logic [pgt_pkg::CHANNEL_BITS-1:0]      blue,
    input  wire logic [pgt_pkg::CHANNEL_BITS-1:0]      red_end,
    input  wire logic [pgt_pkg::CHANNEL_BITS-1:0]      green_end,
    input  wire logic [pgt_pkg::CHANNEL_BITS-1:0]      blue_end,
    input  wire logic                                  done,
    input  wire logic signed [pgt_pkg::OUT_W-1:0]      out_red,
    input  wire logic signed [pgt_pkg::OUT_W-1:0]      out_green,
    input  wire logic signed [pgt_pkg::OUT_W-1:0]      out_blue,
    input  wire logic                                  accepted,
    input  wire logic                                  cfg_we,
    input  wire logic [pgt_pkg::CFG_W-1:0]             cfg_wdata,
    output int                                         mismatch_count,
    output int                                         beats_pending
);

    typedef logic [pgt_pkg::NUM_CH-1:0][pgt_pkg::CHANNEL_BITS-1:0] rgb_t;

    typedef struct packed {
        logic signed [pgt_pkg::OUT_W-1:0] red;
        logic signed [pgt_pkg::OUT_W-1:0] green;
        logic signed [pgt_pkg::OUT_W-1:0] blue;
        logic                             accepted;
    } palette_result_t;

    logic [pgt_pkg::CHANNEL_BITS-1:0] palette_mem [pgt_pkg::TABLE_DEPTH][pgt_pkg::NUM_CH];
    logic [pgt_pkg::CFG_W-1:0]        num_colors_q;
    palette_result_t                  expected_results [$];
    palette_result_t                  oldest;
    int                               result_seq;

    initial mismatch_count = 0;

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch at result %0d: %s expected %0d got %0d",
                 result_seq, what, want, got);
        mismatch_count++;
    endtask

    // applies one command to the table copy and returns the result it gives
    function automatic palette_result_t run_command(input logic [1:0] act,
                                                    input logic [pgt_pkg::ADDR_W-1:0] idx,
                                                    input logic [pgt_pkg::ADDR_W-1:0] eidx,
                                                    input rgb_t start_rgb,
                                                    input rgb_t end_rgb);
        palette_result_t res;
        int active;
        int span;
        int diff;
        int delta;
        int v;
        int pos;
        active = (int'(num_colors_q) < pgt_pkg::TABLE_DEPTH) ? int'(num_colors_q)
                                                             : pgt_pkg::TABLE_DEPTH;
        res = '0;
        case (act)
            pgt_pkg::ACT_READ:
            begin
                if (int'(idx) < active)
                begin
                    res.accepted = 1'b1;
                    res.red      = {1'b0, palette_mem[idx][0]};
                    res.green    = {1'b0, palette_mem[idx][1]};
                    res.blue     = {1'b0, palette_mem[idx][2]};
                end
                else
                begin
                    res.red   = '1;
                    res.green = '1;
                    res.blue  = '1;
                end
            end
            pgt_pkg::ACT_WRITE:
            begin
                if (int'(idx) < active)
                begin
                    res.accepted = 1'b1;
                    for (int ch = 0; ch < pgt_pkg::NUM_CH; ch++)
                        palette_mem[idx][ch] = start_rgb[ch];
                end
            end
            pgt_pkg::ACT_FILL:
            begin
                if (idx < eidx)
                begin
                    res.accepted = 1'b1;
                    span = int'(eidx) - int'(idx);
                    for (int ch = 0; ch < pgt_pkg::NUM_CH; ch++)
                    begin
                        diff  = int'(end_rgb[ch]) - int'(start_rgb[ch]);
                        delta = diff / span;    // truncates toward zero
                        for (int k = 0; k <= span; k++)
                        begin
                            pos = int'(idx) + k;
                            v   = int'(start_rgb[ch]) + k * delta;
                            if (pos < active && v >= 0)
                                palette_mem[pos][ch] = v[pgt_pkg::CHANNEL_BITS-1:0];
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < pgt_pkg::TABLE_DEPTH; e++)
                for (int ch = 0; ch < pgt_pkg::NUM_CH; ch++)
                    palette_mem[e][ch] = '0;
            num_colors_q = pgt_pkg::NUM_COLORS_RESET;
            expected_results.delete();
            result_seq = 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result beat with nothing pending, accepted", 0,
                                    int'(accepted));
                else
                begin
                    oldest = expected_results.pop_front();
                    if (out_red !== oldest.red)
                        report_mismatch("out_red", int'(oldest.red), int'(out_red));
                    if (out_green !== oldest.green)
                        report_mismatch("out_green", int'(oldest.green), int'(out_green));
                    if (out_blue !== oldest.blue)
                        report_mismatch("out_blue", int'(oldest.blue), int'(out_blue));
                    if (accepted !== oldest.accepted)
                        report_mismatch("accepted", int'(oldest.accepted), int'(accepted));
                end
                result_seq++;
            end
            else if (done !== 1'b0)
                report_mismatch("done not a known level, done", 0, 0);
            if (cfg_we)
                num_colors_q = cfg_wdata;
            if (start && busy === 1'b0)
                expected_results.insert(expected_results.size(),
                                        run_command(action, index, end_index,
                                                    {blue, green, red},
                                                    {blue_end, green_end, red_end}));
        end
        beats_pending = expected_results.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives read, write and gradient fill commands into the palette table
// ----------------------------------------------------------------------------
// A directed opening covers the table extremes, every action code, refused
// and partly out-of-range fills and the size register limits. Then random
// phases, each under its own num_colors setting, send mostly well-formed
// traffic in bursts with random gaps. The checker beside the block predicts
// and compares every result beat; this module only drives and gives the
// verdict.
// ----------------------------------------------------------------------------

module testbench;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int NUM_PHASES   = 9;
    localparam int SETTLE_CYCLES = 8;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [1:0]                         action;
    logic [pgt_pkg::ADDR_W-1:0]         index;
    logic [pgt_pkg::ADDR_W-1:0]         end_index;
    logic [pgt_pkg::CHANNEL_BITS-1:0]   red;
    logic [pgt_pkg::CHANNEL_BITS-1:0]   green;
    logic [pgt_pkg::CHANNEL_BITS-1:0]   blue;
    logic [pgt_pkg::CHANNEL_BITS-1:0]   red_end;
    logic [pgt_pkg::CHANNEL_BITS-1:0]   green_end;
    logic [pgt_pkg::CHANNEL_BITS-1:0]   blue_end;
    logic                               done;
    logic signed [pgt_pkg::OUT_W-1:0]   out_red;
    logic signed [pgt_pkg::OUT_W-1:0]   out_green;
    logic signed [pgt_pkg::OUT_W-1:0]   out_blue;
    logic                               accepted;
    logic                               cfg_we;
    logic [pgt_pkg::CFG_W-1:0]          cfg_wdata;

    int mismatch_count;
    int beats_pending;
    int cycle_count = 0;

    // size setting the stimulus currently aims at, used to hit the range edge
    int cur_num_colors;
    // span of the last accepted fill, so reads can land on fresh gradients
    int last_fill_lo;
    int last_fill_hi;
    bit have_fill;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    palette_gradient_table_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .index     (index),
        .end_index (end_index),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .red_end   (red_end),
        .green_end (green_end),
        .blue_end  (blue_end),
        .done      (done),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .accepted  (accepted),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    palette_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .index          (index),
        .end_index      (end_index),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .red_end        (red_end),
        .green_end      (green_end),
        .blue_end       (blue_end),
        .done           (done),
        .out_red        (out_red),
        .out_green      (out_green),
        .out_blue       (out_blue),
        .accepted       (accepted),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .beats_pending  (beats_pending)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("palette_gradient_table_top test failed");
            $finish;
        end
    end

    // one command beat: fields and start go up at the falling edge, then we
    // hold until a rising edge sees busy low; start stays high afterwards so
    // that back-to-back beats need no extra assignment in the same step
    task automatic send_beat(input logic [1:0] act,
                             input int idx, input int eidx,
                             input int r, input int g, input int b,
                             input int r_end, input int g_end, input int b_end);
        @(negedge clk);
        start     <= 1'b1;
        action    <= act;
        index     <= idx[pgt_pkg::ADDR_W-1:0];
        end_index <= eidx[pgt_pkg::ADDR_W-1:0];
        red       <= r[pgt_pkg::CHANNEL_BITS-1:0];
        green     <= g[pgt_pkg::CHANNEL_BITS-1:0];
        blue      <= b[pgt_pkg::CHANNEL_BITS-1:0];
        red_end   <= r_end[pgt_pkg::CHANNEL_BITS-1:0];
        green_end <= g_end[pgt_pkg::CHANNEL_BITS-1:0];
        blue_end  <= b_end[pgt_pkg::CHANNEL_BITS-1:0];
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (act == pgt_pkg::ACT_FILL && idx < eidx)
        begin
            have_fill    = 1'b1;
            last_fill_lo = idx;
            last_fill_hi = eidx;
        end
    endtask

    // sender gap: drives start low for the length given by n
    task automatic pause(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // drop start and wait for every result beat plus a short settle
    task automatic wait_idle();
        pause(1);
        while (beats_pending != 0 || busy !== 1'b0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // num_colors is only written with the block idle
    task automatic write_num_colors(input int value);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[pgt_pkg::CFG_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_num_colors = value;
    endtask

    // channel level weighted toward the extremes
    function automatic int pick_level();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return 0;
        if (sel < 30)
            return 255;
        return $urandom_range(255);
    endfunction

    // entry index: uniform, near the active size edge, or in a busy low region
    function automatic int pick_index();
        int sel;
        int edge_at;
        int near;
        sel = $urandom_range(99);
        edge_at = (cur_num_colors > pgt_pkg::TABLE_DEPTH) ? pgt_pkg::TABLE_DEPTH
                                                          : cur_num_colors;
        if (sel < 50)
            return $urandom_range(255);
        if (sel < 80)
        begin
            near = edge_at - 2 + $urandom_range(3);
            if (near < 0)
                near = 0;
            if (near > 255)
                near = 255;
            return near;
        end
        return $urandom_range(15);
    endfunction

    // one random command; mostly well-formed fills, writes and reads with a
    // tail of refused fills and the unused action code
    task automatic random_beat();
        int sel;
        int idx;
        int eidx;
        int span;
        sel = $urandom_range(99);
        if (sel < 35)
        begin
            if (have_fill && $urandom_range(1) == 1)
                idx = $urandom_range(last_fill_hi, last_fill_lo);
            else
                idx = pick_index();
            send_beat(pgt_pkg::ACT_READ, idx, $urandom_range(255),
                      $urandom_range(255), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255), $urandom_range(255));
        end
        else if (sel < 63)
            send_beat(pgt_pkg::ACT_WRITE, pick_index(), $urandom_range(255),
                      pick_level(), pick_level(), pick_level(),
                      $urandom_range(255), $urandom_range(255), $urandom_range(255));
        else if (sel < 90)
        begin
            // most fills are short, a few walk a long span
            sel = $urandom_range(99);
            if (sel < 80)
                span = $urandom_range(8, 1);
            else if (sel < 95)
                span = $urandom_range(40, 9);
            else
                span = $urandom_range(255, 1);
            if ($urandom_range(3) == 0)
                idx = pick_index();
            else
                idx = $urandom_range(255);
            if (idx + span > 255)
                idx = 255 - span;
            send_beat(pgt_pkg::ACT_FILL, idx, idx + span,
                      pick_level(), pick_level(), pick_level(),
                      pick_level(), pick_level(), pick_level());
        end
        else if (sel < 96)
        begin
            // start at or past end: refused
            idx  = $urandom_range(255);
            eidx = $urandom_range(idx);
            send_beat(pgt_pkg::ACT_FILL, idx, eidx,
                      $urandom_range(255), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255), $urandom_range(255));
        end
        else
            send_beat(pgt_pkg::ACT_NONE, $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255), $urandom_range(255));
    endtask

    // short hand-picked opening
    task automatic directed_beats();
        // reset contents are black over the full table
        send_beat(pgt_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(pgt_pkg::ACT_READ, 255, 0, 0, 0, 0, 0, 0, 0);
        send_beat(pgt_pkg::ACT_WRITE, 0, 0, 255, 255, 255, 0, 0, 0);
        send_beat(pgt_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(pgt_pkg::ACT_WRITE, 255, 0, 8'hAA, 8'h55, 8'hFF, 0, 0, 0);
        send_beat(pgt_pkg::ACT_READ, 255, 0, 0, 0, 0, 0, 0, 0);
        // whole-table fill, deltas of +1 and -1
        send_beat(pgt_pkg::ACT_FILL, 0, 255, 0, 255, 0, 255, 0, 255);
        send_beat(pgt_pkg::ACT_READ, 128, 0, 0, 0, 0, 0, 0, 0);
        send_beat(pgt_pkg::ACT_READ, 255, 0, 0, 0, 0, 0, 0, 0);
        // steep negative, positive and flat channels
        send_beat(pgt_pkg::ACT_FILL, 10, 13, 255, 0, 7, 0, 255, 7);
        send_beat(pgt_pkg::ACT_READ, 11, 0, 0, 0, 0, 0, 0, 0);
        send_beat(pgt_pkg::ACT_READ, 13, 0, 0, 0, 0, 0, 0, 0);
        // fill with start equal to end, then start past end: both refused
        send_beat(pgt_pkg::ACT_FILL, 20, 20, 9, 9, 9, 99, 99, 99);
        send_beat(pgt_pkg::ACT_FILL, 30, 25, 9, 9, 9, 99, 99, 99);
        // unused action code with every field at its top
        send_beat(pgt_pkg::ACT_NONE, 255, 255, 255, 255, 255, 255, 255, 255);
        send_beat(pgt_pkg::ACT_READ, 30, 0, 0, 0, 0, 0, 0, 0);
        // quotients that truncate to zero from both signs
        send_beat(pgt_pkg::ACT_FILL, 0, 3, 0, 2, 100, 2, 0, 98);
        send_beat(pgt_pkg::ACT_READ, 2, 0, 0, 0, 0, 0, 0, 0);
        // empty table: every read and write out of range, fill skips all
        write_num_colors(0);
        send_beat(pgt_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(pgt_pkg::ACT_WRITE, 0, 0, 1, 1, 1, 0, 0, 0);
        send_beat(pgt_pkg::ACT_FILL, 0, 2, 50, 50, 50, 60, 60, 60);
        // single entry: fill runs past the size and only entry 0 lands
        write_num_colors(1);
        send_beat(pgt_pkg::ACT_WRITE, 0, 0, 1, 2, 3, 0, 0, 0);
        send_beat(pgt_pkg::ACT_READ, 1, 0, 0, 0, 0, 0, 0, 0);
        send_beat(pgt_pkg::ACT_FILL, 0, 4, 9, 9, 9, 1, 1, 1);
        send_beat(pgt_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        // register above the table depth clamps to the full table
        write_num_colors(511);
        send_beat(pgt_pkg::ACT_READ, 255, 0, 0, 0, 0, 0, 0, 0);
    endtask

    initial
    begin : stimulus
        int phase_colors [NUM_PHASES];
        int burst_left;
        int per_phase;
        phase_colors = '{256, 1, 200, 511, 0, 255, 64, -1, 256};
        per_phase    = RANDOM_ITEMS / NUM_PHASES;

        // every input known from time zero
        rst_n     = 1'b0;
        start     = 1'b0;
        action    = pgt_pkg::ACT_READ;
        index     = '0;
        end_index = '0;
        red       = '0;
        green     = '0;
        blue      = '0;
        red_end   = '0;
        green_end = '0;
        blue_end  = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        cur_num_colors = 256;
        have_fill = 1'b0;
        last_fill_lo = 0;
        last_fill_hi = 0;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        directed_beats();

        // random phases, each under its own size setting; -1 picks one
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (phase_colors[p] < 0)
                write_num_colors($urandom_range(511));
            else
                write_num_colors(phase_colors[p]);
            have_fill  = 1'b0;
            burst_left = $urandom_range(24, 1);
            for (int n = 0; n < per_phase; n++)
            begin
                random_beat();
                burst_left--;
                if (burst_left == 0)
                begin
                    // a quarter of the bursts run straight into the next one
                    if ($urandom_range(3) != 0)
                        pause($urandom_range(15, 1));
                    burst_left = $urandom_range(24, 1);
                end
            end
        end

        wait_idle();

        if (mismatch_count == 0)
            $display("palette_gradient_table_top test passed");
        else
            $display("palette_gradient_table_top test failed");
        $finish;
    end

endmodule
